// File: hdl/onoff_pkg.sv
// types and constants shared by the on/off timed-off controller
// no dependencies
`default_nettype none
package onoff_pkg;

  localparam int NUM_ENDPOINTS = 8;
  localparam int IDX_W = $clog2(NUM_ENDPOINTS);

  // command codes
  localparam logic [7:0] CMD_OFF          = 8'd0;
  localparam logic [7:0] CMD_ON           = 8'd1;
  localparam logic [7:0] CMD_TOGGLE       = 8'd2;
  localparam logic [7:0] CMD_OFF_EFFECT   = 8'd64;
  localparam logic [7:0] CMD_RECALL_SCENE = 8'd65;
  localparam logic [7:0] CMD_TIMED_OFF    = 8'd66;

  // result status codes
  localparam logic [1:0] ST_HANDLED   = 2'd0;
  localparam logic [1:0] ST_OUT_RANGE = 2'd1;
  localparam logic [1:0] ST_UNKNOWN   = 2'd2;
  localparam logic [1:0] ST_REJECTED  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_BASE_ENDPOINT  = 2'd0;
  localparam logic [1:0] CFG_BLE_MODE_MASK  = 2'd1;
  localparam logic [1:0] CFG_NETWORK_JOINED = 2'd2;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic        on;
    logic [15:0] on_time;
    logic [15:0] off_wait;
    logic        scene;
    logic        timer;
    logic        remote;
  } ep_state_t;

  typedef struct packed {
    logic light_write;
    logic light_level;
    logic send_request;
    logic send_value;
  } drive_t;

  typedef struct packed {
    ep_state_t st;
    drive_t    drv;
  } step_t;

  localparam ep_state_t EP_RESET = '{
    on: 1'b0, on_time: 16'd0, off_wait: 16'd0, scene: 1'b1, timer: 1'b0, remote: 1'b0
  };

endpackage
`default_nettype wire

// File: hdl/onoff_timed_off_controller.sv
// top level of the on/off timed-off controller: per-endpoint state and result register
// depends on onoff_pkg
//
// usage
//   input channel: a word (command or 100 ms tick for one endpoint) is taken at a
//   rising edge with start high and busy low. busy is low whenever the block is
//   out of reset, so a word can be offered in every cycle.
//   result channel: one result word per input word, shown on the out_ ports for
//   exactly one cycle with out_strobe high. the receiver cannot stall, so no
//   result is ever held back.
//   config port: cfg_we, cfg_index and cfg_wdata write base_endpoint,
//   ble_mode_mask and network_joined at a rising edge; index 3 is ignored.
// timing
//   a taken word goes first into the input register; from there the endpoint's
//   state is updated and the result register loaded, and out_strobe is driven
//   from the result register. throughput is one word per cycle, set by
//   the single read-modify-write of one endpoint's state register.
//   back-to-back words to the same endpoint see each other's update directly.
// reset
//   synchronous active-low rst_n puts every endpoint off with zero counters,
//   stopped timer and scene control set, and the config registers to their defaults.
`default_nettype none
module onoff_timed_off_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_endpoint,
  input  wire logic [7:0]  in_command_id,
  input  wire logic        in_accept_only_when_on,
  input  wire logic [15:0] in_on_time_arg,
  input  wire logic [15:0] in_off_wait_arg,
  // result channel
  output logic             out_strobe,
  output logic [1:0]       out_status,
  output logic [2:0]       out_endpoint_index,
  output logic             out_is_on,
  output logic [15:0]      out_on_time_left,
  output logic [15:0]      out_off_wait_left,
  output logic             out_timer_active,
  output logic             out_scene_control,
  output logic             out_light_write,
  output logic             out_light_level,
  output logic             out_send_request,
  output logic             out_send_value,
  // config port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int N = onoff_pkg::NUM_ENDPOINTS;
  localparam int IW = onoff_pkg::IDX_W;

  // config registers
  logic [7:0] base_ep_r;
  logic [7:0] ble_mask_r;
  logic       joined_r;

  // input register
  logic        in_vld_r;
  logic        mode_r;
  logic [7:0]  ep_r;
  logic [7:0]  cmd_r;
  logic        only_on_r;
  logic [15:0] on_arg_r;
  logic [15:0] wait_arg_r;

  // per-endpoint state
  onoff_pkg::ep_state_t state_r [N];

  // datapath
  logic [8:0]           ep_diff;
  logic                 out_range;
  logic [IW-1:0]        idx;
  logic                 ble;
  logic                 is_zero;
  onoff_pkg::ep_state_t cur;
  onoff_pkg::step_t     stp;
  logic [1:0]           status;
  logic                 stop_early;

  // result register
  logic        strobe_r;
  logic [1:0]  status_r;
  logic [2:0]  idx_out_r;
  onoff_pkg::ep_state_t res_st_r;
  onoff_pkg::drive_t    res_drv_r;

  // turn one endpoint on or off, with the side effects on light and bound devices
  function automatic onoff_pkg::step_t set_onoff(onoff_pkg::step_t s, logic val,
                                                 logic ble_bit, logic zero_idx,
                                                 logic joined);
    onoff_pkg::step_t r;
    r = s;
    if (val) begin
      r.st.scene = 1'b1;
      if (r.st.on_time == 16'd0) begin
        r.st.off_wait = 16'd0;
      end
    end else begin
      r.st.on_time = 16'd0;
    end
    r.st.on = val;
    if (!ble_bit || !val) begin
      r.st.remote = val;
      if (zero_idx) begin
        r.drv.light_write = 1'b1;
        r.drv.light_level = val;
      end
      if (joined) begin
        r.drv.send_request = 1'b1;
        r.drv.send_value   = val;
      end
    end
    return r;
  endfunction

  assign busy = ~rst_n;

  // range check without wrap
  assign ep_diff   = {1'b0, ep_r} - {1'b0, base_ep_r};
  assign out_range = ep_diff[8] || (ep_diff[7:0] >= 8'(N));
  assign idx       = ep_diff[IW-1:0];
  assign ble       = ble_mask_r[idx];
  assign is_zero   = (idx == '0);
  assign cur       = state_r[idx];

  always_comb begin
    stp        = '{st: cur, drv: '0};
    status     = onoff_pkg::ST_HANDLED;
    stop_early = 1'b0;
    if (mode_r) begin
      // 100 ms tick
      if (cur.timer) begin
        if (stp.st.on && stp.st.on_time != 16'd0) begin
          stp.st.on_time = stp.st.on_time - 16'd1;
          if (stp.st.on_time == 16'd0) begin
            stp.st.off_wait = 16'd0;
            stp = set_onoff(stp, 1'b0, ble, is_zero, joined_r);
          end
        end
        if (!stp.st.on && stp.st.off_wait != 16'd0) begin
          stp.st.off_wait = stp.st.off_wait - 16'd1;
          if (stp.st.off_wait == 16'd0) begin
            stp.st.timer = 1'b0;
            stop_early   = 1'b1;
          end
        end
        if (!stop_early && stp.st.on_time == 16'd0 && stp.st.off_wait == 16'd0) begin
          stp.st.timer = 1'b0;
        end
      end
    end else begin
      case (cmd_r)
        onoff_pkg::CMD_OFF:    stp = set_onoff(stp, 1'b0, ble, is_zero, joined_r);
        onoff_pkg::CMD_ON:     stp = set_onoff(stp, 1'b1, ble, is_zero, joined_r);
        onoff_pkg::CMD_TOGGLE: stp = set_onoff(stp, ~cur.on, ble, is_zero, joined_r);
        onoff_pkg::CMD_OFF_EFFECT: begin
          stp.st.scene = 1'b0;
          stp = set_onoff(stp, 1'b0, ble, is_zero, joined_r);
        end
        onoff_pkg::CMD_RECALL_SCENE: stp.st.scene = 1'b1;
        onoff_pkg::CMD_TIMED_OFF: begin
          if (only_on_r && !cur.on) begin
            status = onoff_pkg::ST_REJECTED;
          end else begin
            if (cur.off_wait != 16'd0 && !cur.on) begin
              // already waiting while off: only shorten the wait
              if (wait_arg_r < cur.off_wait) begin
                stp.st.off_wait = wait_arg_r;
              end
            end else begin
              if (on_arg_r > cur.on_time) begin
                stp.st.on_time = on_arg_r;
              end
              stp.st.off_wait = wait_arg_r;
              stp = set_onoff(stp, 1'b1, ble, is_zero, joined_r);
            end
            // a counter at its maximum means no countdown
            if (stp.st.on_time < onoff_pkg::COUNT_MAX &&
                stp.st.off_wait < onoff_pkg::COUNT_MAX &&
                (stp.st.on_time != 16'd0 || stp.st.off_wait != 16'd0)) begin
              stp.st.timer = 1'b1;
            end
          end
        end
        default: status = onoff_pkg::ST_UNKNOWN;
      endcase
    end
  end

  // config writes and input capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_ep_r  <= 8'd1;
      ble_mask_r <= 8'd0;
      joined_r   <= 1'b1;
      in_vld_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          onoff_pkg::CFG_BASE_ENDPOINT:  base_ep_r  <= cfg_wdata;
          onoff_pkg::CFG_BLE_MODE_MASK:  ble_mask_r <= cfg_wdata;
          onoff_pkg::CFG_NETWORK_JOINED: joined_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      mode_r     <= in_mode;
      ep_r       <= in_endpoint;
      cmd_r      <= in_command_id;
      only_on_r  <= in_accept_only_when_on;
      on_arg_r   <= in_on_time_arg;
      wait_arg_r <= in_off_wait_arg;
    end
  end

  // state write-back, only for an endpoint in range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        state_r[i] <= onoff_pkg::EP_RESET;
      end
    end else if (in_vld_r && !out_range) begin
      state_r[idx] <= stp.st;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      if (out_range) begin
        status_r  <= onoff_pkg::ST_OUT_RANGE;
        idx_out_r <= 3'd0;
        res_st_r  <= '0;
        res_drv_r <= '0;
      end else begin
        status_r  <= status;
        idx_out_r <= 3'(idx);
        res_st_r  <= stp.st;
        res_drv_r <= stp.drv;
      end
    end
  end

  assign out_strobe         = strobe_r;
  assign out_status         = status_r;
  assign out_endpoint_index = idx_out_r;
  assign out_is_on          = res_st_r.on;
  assign out_on_time_left   = res_st_r.on_time;
  assign out_off_wait_left  = res_st_r.off_wait;
  assign out_timer_active   = res_st_r.timer;
  assign out_scene_control  = res_st_r.scene;
  assign out_light_write    = res_drv_r.light_write;
  assign out_light_level    = res_drv_r.light_level;
  assign out_send_request   = res_drv_r.send_request;
  assign out_send_value     = res_drv_r.send_value;

endmodule
`default_nettype wire

// File: tb/sv/onoff_timed_off_controller_test.sv
// self-checking testbench for the on/off timed-off controller
// depends on onoff_pkg and onoff_timed_off_controller; predicts every result word
// from its own copy of the per-endpoint switch state
`timescale 1ns / 1ps
module onoff_timed_off_controller_test;
  import onoff_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 270;

  // item kinds and register index that the block ignores
  localparam logic MODE_CMD = 1'b0;
  localparam logic MODE_TICK = 1'b1;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  // command ids outside the known set
  localparam logic [7:0] CMD_UNDEFINED_LO = 8'd3;
  localparam logic [7:0] CMD_UNDEFINED_HI = 8'hFF;

  typedef struct packed {
    logic        mode;
    logic [7:0]  endpoint;
    logic [7:0]  command_id;
    logic        only_on;
    logic [15:0] on_arg;
    logic [15:0] wait_arg;
  } switch_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] index;
    logic             is_on;
    logic [15:0]      on_time;
    logic [15:0]      off_wait;
    logic             timer;
    logic             scene;
    drive_t           drv;
  } switch_result_t;

  // clock, reset and dut ports, the driven ones all known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_mode = 1'b0;
  logic [7:0]  in_endpoint = 8'd0;
  logic [7:0]  in_command_id = 8'd0;
  logic        in_accept_only_when_on = 1'b0;
  logic [15:0] in_on_time_arg = 16'd0;
  logic [15:0] in_off_wait_arg = 16'd0;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic [2:0]  out_endpoint_index;
  logic        out_is_on;
  logic [15:0] out_on_time_left;
  logic [15:0] out_off_wait_left;
  logic        out_timer_active;
  logic        out_scene_control;
  logic        out_light_write;
  logic        out_light_level;
  logic        out_send_request;
  logic        out_send_value;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_wdata = 8'd0;

  always #6 clk = ~clk;

  onoff_timed_off_controller uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_endpoint(in_endpoint),
    .in_command_id(in_command_id),
    .in_accept_only_when_on(in_accept_only_when_on),
    .in_on_time_arg(in_on_time_arg),
    .in_off_wait_arg(in_off_wait_arg),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_endpoint_index(out_endpoint_index),
    .out_is_on(out_is_on),
    .out_on_time_left(out_on_time_left),
    .out_off_wait_left(out_off_wait_left),
    .out_timer_active(out_timer_active),
    .out_scene_control(out_scene_control),
    .out_light_write(out_light_write),
    .out_light_level(out_light_level),
    .out_send_request(out_send_request),
    .out_send_value(out_send_value),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // words waiting to be sent and result words still owed by the block
  switch_word_t   pending_words[$];
  switch_result_t expected_results[$];
  switch_word_t   on_air;
  int words_queued = 0;
  int words_accepted = 0;
  int mismatches = 0;
  int cycles = 0;
  bit sender_gaps = 1'b1;

  // predictor copy of the registers and the per-endpoint switch state
  logic [7:0] base_ep;
  logic [7:0] ble_mask;
  logic       joined;
  ep_state_t  sw_st[NUM_ENDPOINTS];
  drive_t     drv;

  logic [7:0] known_cmds[6] = '{CMD_OFF, CMD_ON, CMD_TOGGLE, CMD_OFF_EFFECT,
                                CMD_RECALL_SCENE, CMD_TIMED_OFF};

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // every change of the on/off attribute goes through here
  function automatic void switch_onoff(int idx, logic val);
    if (val) begin
      sw_st[idx].scene = 1'b1;
      // turning on with no on time left drops any pending off wait
      if (sw_st[idx].on_time == 16'd0) sw_st[idx].off_wait = 16'd0;
    end else begin
      sw_st[idx].on_time = 16'd0;
    end
    sw_st[idx].on = val;
    // ble endpoints only drive and send on the way off
    if (!ble_mask[idx] || !val) begin
      sw_st[idx].remote = val;
      if (idx == 0) begin
        drv.light_write = 1'b1;
        drv.light_level = val;
      end
      if (joined) begin
        drv.send_request = 1'b1;
        drv.send_value = val;
      end
    end
  endfunction

  // one 100 ms step of the countdown timer
  function automatic void countdown(int idx);
    if (!sw_st[idx].timer) return;
    if (sw_st[idx].on && sw_st[idx].on_time != 16'd0) begin
      sw_st[idx].on_time = sw_st[idx].on_time - 16'd1;
      if (sw_st[idx].on_time == 16'd0) begin
        sw_st[idx].off_wait = 16'd0;
        switch_onoff(idx, 1'b0);
      end
    end
    if (!sw_st[idx].on && sw_st[idx].off_wait != 16'd0) begin
      sw_st[idx].off_wait = sw_st[idx].off_wait - 16'd1;
      if (sw_st[idx].off_wait == 16'd0) begin
        sw_st[idx].timer = 1'b0;
        return;
      end
    end
    if (sw_st[idx].on_time == 16'd0 && sw_st[idx].off_wait == 16'd0)
      sw_st[idx].timer = 1'b0;
  endfunction

  // on-with-timed-off: max rule on on time, min rule on off wait while off
  function automatic logic [1:0] timed_off(int idx, switch_word_t w);
    if (w.only_on && !sw_st[idx].on) return ST_REJECTED;
    if (sw_st[idx].off_wait != 16'd0 && !sw_st[idx].on) begin
      if (w.wait_arg < sw_st[idx].off_wait) sw_st[idx].off_wait = w.wait_arg;
    end else begin
      if (w.on_arg > sw_st[idx].on_time) sw_st[idx].on_time = w.on_arg;
      sw_st[idx].off_wait = w.wait_arg;
      switch_onoff(idx, 1'b1);
    end
    // a saturated counter leaves the timer as it was
    if (sw_st[idx].on_time < COUNT_MAX && sw_st[idx].off_wait < COUNT_MAX &&
        (sw_st[idx].on_time != 16'd0 || sw_st[idx].off_wait != 16'd0))
      sw_st[idx].timer = 1'b1;
    return ST_HANDLED;
  endfunction

  function automatic switch_result_t predict_switch(switch_word_t w);
    switch_result_t r;
    int rel;
    int idx;
    r = '0;
    drv = '0;
    // no wrap past endpoint 255
    rel = int'(w.endpoint) - int'(base_ep);
    if (rel < 0 || rel >= NUM_ENDPOINTS) begin
      r.status = ST_OUT_RANGE;
      return r;
    end
    idx = rel;
    r.status = ST_HANDLED;
    if (w.mode == MODE_TICK) begin
      countdown(idx);
    end else begin
      case (w.command_id)
        CMD_OFF:    switch_onoff(idx, 1'b0);
        CMD_ON:     switch_onoff(idx, 1'b1);
        CMD_TOGGLE: switch_onoff(idx, !sw_st[idx].on);
        CMD_OFF_EFFECT: begin
          sw_st[idx].scene = 1'b0;
          switch_onoff(idx, 1'b0);
        end
        CMD_RECALL_SCENE: sw_st[idx].scene = 1'b1;
        CMD_TIMED_OFF:    r.status = timed_off(idx, w);
        default:          r.status = ST_UNKNOWN;
      endcase
    end
    r.index = idx[IDX_W-1:0];
    r.is_on = sw_st[idx].on;
    r.on_time = sw_st[idx].on_time;
    r.off_wait = sw_st[idx].off_wait;
    r.timer = sw_st[idx].timer;
    r.scene = sw_st[idx].scene;
    r.drv = drv;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void queue_word(logic mode, logic [7:0] ep, logic [7:0] cmd,
                                     logic only_on, logic [15:0] on_arg,
                                     logic [15:0] wait_arg);
    switch_word_t w;
    w.mode = mode;
    w.endpoint = ep;
    w.command_id = cmd;
    w.only_on = only_on;
    w.on_arg = on_arg;
    w.wait_arg = wait_arg;
    pending_words.push_back(w);
    words_queued++;
  endfunction

  // endpoint that maps to a controller index under the current base
  function automatic logic [7:0] pick_endpoint();
    int top;
    top = 255 - int'(base_ep);
    if (top > NUM_ENDPOINTS - 1) top = NUM_ENDPOINTS - 1;
    return base_ep + 8'($urandom_range(0, top));
  endfunction

  // mostly short counts so the countdown reaches zero, sometimes saturated
  function automatic logic [15:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 16'($urandom_range(0, 6));
    if (r < 80) return 16'($urandom_range(0, 65535));
    if (r < 90) return COUNT_MAX;
    if (r < 95) return COUNT_MAX - 16'd1;
    return 16'($urandom_range(7, 40));
  endfunction

  function automatic logic [7:0] pick_command();
    return known_cmds[$urandom_range(0, 5)];
  endfunction

  // corners under base 1, no ble endpoints, network joined
  function automatic void queue_directed();
    queue_word(MODE_TICK, 8'd1, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF); // tick, timer stopped
    queue_word(MODE_CMD, 8'd0, CMD_ON, 1'b0, 16'd0, 16'd0);       // below base
    queue_word(MODE_CMD, 8'd9, CMD_ON, 1'b0, 16'd0, 16'd0);       // one past last index
    queue_word(MODE_TICK, 8'd255, CMD_OFF, 1'b0, 16'd0, 16'd0);   // tick out of range
    queue_word(MODE_CMD, 8'd1, CMD_UNDEFINED_LO, 1'b0, 16'd0, 16'd0);
    queue_word(MODE_CMD, 8'd8, CMD_UNDEFINED_HI, 1'b1, 16'd5, 16'd5);
    queue_word(MODE_CMD, 8'd2, CMD_TIMED_OFF, 1'b1, 16'd10, 16'd10); // rejected while off
    // index zero drives the light
    queue_word(MODE_CMD, 8'd1, CMD_ON, 1'b0, 16'd0, 16'd0);
    queue_word(MODE_CMD, 8'd1, CMD_OFF, 1'b0, 16'd0, 16'd0);
    queue_word(MODE_CMD, 8'd1, CMD_TOGGLE, 1'b0, 16'd0, 16'd0);
    queue_word(MODE_CMD, 8'd1, CMD_TOGGLE, 1'b0, 16'd0, 16'd0);
    queue_word(MODE_CMD, 8'd3, CMD_OFF_EFFECT, 1'b0, 16'd0, 16'd0);
    queue_word(MODE_CMD, 8'd3, CMD_RECALL_SCENE, 1'b0, 16'd0, 16'd0);
    // timer armed, plain on while it runs, then count down until the on time runs out
    queue_word(MODE_CMD, 8'd1, CMD_TIMED_OFF, 1'b0, 16'd2, 16'd3);
    queue_word(MODE_TICK, 8'd1, 8'd0, 1'b0, 16'd0, 16'd0);
    queue_word(MODE_CMD, 8'd1, CMD_ON, 1'b0, 16'd0, 16'd0);
    repeat (5) queue_word(MODE_TICK, 8'd1, 8'd0, 1'b0, 16'd0, 16'd0);
    // saturated counters leave the timer stopped
    queue_word(MODE_CMD, 8'd4, CMD_TIMED_OFF, 1'b0, 16'hFFFF, 16'hFFFF);
    queue_word(MODE_CMD, 8'd4, CMD_TIMED_OFF, 1'b1, 16'd5, 16'd0);
    // off wait left while off: min rule
    queue_word(MODE_CMD, 8'd5, CMD_TIMED_OFF, 1'b0, 16'd10, 16'd20);
    queue_word(MODE_CMD, 8'd5, CMD_OFF, 1'b0, 16'd0, 16'd0);
    queue_word(MODE_CMD, 8'd5, CMD_TIMED_OFF, 1'b0, 16'd3, 16'd7);
    queue_word(MODE_CMD, 8'd5, CMD_TIMED_OFF, 1'b0, 16'd0, 16'd50);
  endfunction

  // random traffic: mostly timed-off followed by its countdown, some noise
  function automatic void queue_random(int n);
    int made;
    int r;
    int k;
    logic [7:0] ep;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      ep = pick_endpoint();
      if (r < 55) begin
        queue_word(MODE_CMD, ep, CMD_TIMED_OFF, ($urandom_range(0, 3) == 0),
                   pick_count(), pick_count());
        k = $urandom_range(1, 14);
        made += 1 + k;
        repeat (k) begin
          if ($urandom_range(0, 5) == 0)
            queue_word(MODE_CMD, ep, pick_command(), 1'($urandom_range(0, 1)),
                       pick_count(), pick_count());
          else
            queue_word(MODE_TICK, ep, 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)));
        end
      end else if (r < 80) begin
        queue_word(MODE_CMD, ep, pick_command(), 1'($urandom_range(0, 1)),
                   pick_count(), pick_count());
        made++;
      end else if (r < 90) begin
        queue_word(MODE_TICK, ep, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        made++;
      end else begin
        // any endpoint, any command id, any kind
        queue_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        made++;
      end
    end
  endfunction

  // sender holds off until every word is taken and every result is back
  task automatic drain();
    while (words_accepted != words_queued || expected_results.size() != 0)
      @(posedge clk);
    // margin before the next phase
    repeat (4) @(posedge clk);
  endtask

  // called at a clock edge with the block idle; leaves cfg_we high
  task automatic write_reg(logic [1:0] index, logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    case (index)
      CFG_BASE_ENDPOINT:  base_ep = value;
      CFG_BLE_MODE_MASK:  ble_mask = value;
      CFG_NETWORK_JOINED: joined = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_regs(logic [7:0] base, logic [7:0] mask, logic net);
    write_reg(CFG_BASE_ENDPOINT, base);
    write_reg(CFG_BLE_MODE_MASK, mask);
    write_reg(CFG_NETWORK_JOINED, {7'd0, net});
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // driver: offers the next pending word; with sender_gaps set it idles about one cycle in ten
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      // word taken at this edge: predict its result now
      if (start && !busy) begin
        expected_results.push_back(predict_switch(on_air));
        words_accepted++;
      end
      if (start && busy) begin
        // keep the same word on the ports until it is taken
      end else if (pending_words.size() != 0 &&
                   !(sender_gaps && $urandom_range(0, 99) < 10)) begin
        on_air = pending_words.pop_front();
        start <= 1'b1;
        in_mode <= on_air.mode;
        in_endpoint <= on_air.endpoint;
        in_command_id <= on_air.command_id;
        in_accept_only_when_on <= on_air.only_on;
        in_on_time_arg <= on_air.on_arg;
        in_off_wait_arg <= on_air.wait_arg;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: every strobed result word against the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    switch_result_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result word with no prediction pending");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 16'(want.status), 16'(out_status));
        check_field("out_endpoint_index", 16'(want.index), 16'(out_endpoint_index));
        check_field("is_on", 16'(want.is_on), 16'(out_is_on));
        check_field("on_time_left", want.on_time, out_on_time_left);
        check_field("off_wait_left", want.off_wait, out_off_wait_left);
        check_field("timer_active", 16'(want.timer), 16'(out_timer_active));
        check_field("scene_control", 16'(want.scene), 16'(out_scene_control));
        check_field("light_write", 16'(want.drv.light_write), 16'(out_light_write));
        check_field("light_level", 16'(want.drv.light_level), 16'(out_light_level));
        check_field("send_request", 16'(want.drv.send_request), 16'(out_send_request));
        check_field("send_value", 16'(want.drv.send_value), 16'(out_send_value));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("onoff_timed_off_controller_test NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // test sequence: one register setting per phase, idle between phases
  // --------------------------------------------------------------------------
  initial begin
    // predictor starts from the reset state
    for (int i = 0; i < NUM_ENDPOINTS; i++) sw_st[i] = EP_RESET;
    base_ep = 8'd1;
    ble_mask = 8'h00;
    joined = 1'b1;
    drv = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults written explicitly, corners first
    program_regs(8'd1, 8'h00, 1'b1);
    queue_directed();
    queue_random(RANDOM_WORDS);
    drain();

    // lowest base, every endpoint on ble, not joined
    program_regs(8'd0, 8'hFF, 1'b0);
    queue_random(RANDOM_WORDS);
    drain();

    // top range ends exactly at 255; long stretch with no sender gaps
    sender_gaps = 1'b0;
    program_regs(8'd248, 8'h55, 1'b1);
    queue_random(RANDOM_WORDS);
    drain();
    sender_gaps = 1'b1;

    // write to the unused index is ignored; then only index zero in range
    write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
    program_regs(8'd255, 8'hAA, 1'b1);
    queue_random(RANDOM_WORDS);
    drain();

    // random setting
    program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
    queue_random(RANDOM_WORDS);
    drain();

    if (mismatches == 0) begin
      $display("onoff_timed_off_controller_test OK");
    end else begin
      $display("onoff_timed_off_controller_test NOT OK");
    end
    $finish;
  end

endmodule
